[rtl/jacobi_7pt_stencil_3d_core_assert.svh]
// ---------------------------------------------------------------------------
// Jacobi 7-point stencil core assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef JACOBI_7PT_STENCIL_3D_CORE_ASSERT_SVH
`define JACOBI_7PT_STENCIL_3D_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define J7S3_ASSERT_IMP(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("j7s3 assertion failed");
// next-cycle implication
`define J7S3_ASSERT_NXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("j7s3 assertion failed");
`else
`define J7S3_ASSERT_IMP(name, clk, rstn, ante, cons)
`define J7S3_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

[rtl/j7s3_pkg.sv]
// ---------------------------------------------------------------------------
// j7s3_pkg
// Shared constants and types of the Jacobi 7-point stencil core.
// ---------------------------------------------------------------------------
package j7s3_pkg;

	// default geometry and value width
	localparam int DEF_MAX_X      = 128;
	localparam int DEF_MAX_Y      = 128;
	localparam int DEF_VALUE_BITS = 32;

	// port field widths
	localparam int NODE_W  = 32;
	localparam int COORD_XW = 7;
	localparam int COORD_YW = 7;
	localparam int COORD_ZW = 16;
	localparam int RES_W    = 64;
	localparam int OUT_W    = 128;
	localparam int CFG_W    = 16;
	localparam int CFG_IW   = 2;

	// register indexes
	localparam logic [CFG_IW-1:0] CFG_SIZE_X = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_SIZE_Y = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_SIZE_Z = 2'd2;

	// register reset value
	localparam logic [15:0] SIZE_RST = 16'd128;

	// number of window reads per interior node
	localparam int N_READS = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_DIFF,
		ST_MUL,
		ST_ACC
	} state_t;

endpackage

[rtl/j7s3_ram.sv]
// ---------------------------------------------------------------------------
// j7s3_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module j7s3_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/jacobi_7pt_stencil_3d_core.sv]
// ---------------------------------------------------------------------------
// jacobi_7pt_stencil_3d_core
// One Jacobi sweep of a 7-point stencil over a streamed 3D grid, with a
// saturating residual of squared changes.
// ---------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  node_value
// m_*      out  m_tvalid/m_tready  new_value, node_x, node_y, node_z, residual;
//                                   last_flag on m_tlast
// cfg_*    in   cfg_we             cfg_index, cfg_data (size_x, size_y, size_z)
//
// A boundary node is written to the window RAM and yields no result. An interior
// node goes through the accept step, six reads through the single read port of
// the window RAM, a split reciprocal multiply that divides by six, then
// difference, square and accumulate. No clearing pass after reset:
// window entries are always written before they are read. A stalled output
// holds the core in the accumulate step only when a second result is ready.
// ---------------------------------------------------------------------------
`include "jacobi_7pt_stencil_3d_core_assert.svh"

module jacobi_7pt_stencil_3d_core
	import j7s3_pkg::*;
#(
	parameter int MAX_X      = DEF_MAX_X,
	parameter int MAX_Y      = DEF_MAX_Y,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [NODE_W-1:0]   s_tdata,   // [31:0] node_value
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata,   // [31:0] new_value, [38:32] node_x,
	                                       // [45:39] node_y, [61:46] node_z,
	                                       // [125:62] residual, rest zero
	output logic                m_tlast,
	input  logic                cfg_we,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	localparam int VB        = VALUE_BITS;
	localparam int FB        = VB - 2;
	localparam int DEPTH     = 2 * MAX_X * MAX_Y + 1;
	localparam int AW        = $clog2(DEPTH);
	localparam int XW        = $clog2(MAX_X + 1);
	localparam int YW        = $clog2(MAX_Y + 1);
	localparam int PW        = $clog2(MAX_X * MAX_Y + 1);
	localparam int SW        = VB + 3;
	localparam int DIV_STEPS = 2;
	localparam int DCW       = $clog2(DIV_STEPS + 1);
	localparam int TW        = 2 * VB + 1 - FB;
	// divide by six: halve, then multiply by a reciprocal of three
	localparam int MW        = SW - 1;
	localparam int MLW       = (MW + 1) / 2;
	localparam int MHW       = MW - MLW;
	localparam int RK        = VB + 4;
	localparam int RW        = RK - 1;
	localparam logic [RW-1:0] RECIP3 = RW'(((64'd1 << RK) + 64'd2) / 64'd3);
	localparam int PRW       = MW + RW;

	state_t state_q, state_nx;

	// configuration
	logic [7:0]  size_x_q, size_y_q;
	logic [15:0] size_z_q;
	logic        cfg_hit;

	// position and residual
	logic [XW-1:0]    pos_x_q;
	logic [YW-1:0]    pos_y_q;
	logic [15:0]      pos_z_q;
	logic [RES_W-1:0] res_q;
	logic [AW-1:0]    wptr_q;

	// item work registers
	logic [AW-1:0]        iptr_q;
	logic signed [SW-1:0] sum_q;
	logic signed [VB-1:0] center_q;
	logic [2:0]           rd_cnt_q;
	logic [SW-1:0]        dvd_q;
	logic [MLW+RW-1:0]    plo_q;
	logic [VB-1:0]        quo_q;
	logic [DCW-1:0]       div_cnt_q;
	logic [VB-1:0]        ad_q;
	logic [2*VB-1:0]      sq_q;
	logic [COORD_XW-1:0]  ox_q;
	logic [COORD_YW-1:0]  oy_q;
	logic [COORD_ZW-1:0]  oz_q;
	logic                 last_q;

	// output register
	logic                 ovalid_q;
	logic signed [VB-1:0] onew_q;
	logic [COORD_XW-1:0]  onx_q;
	logic [COORD_YW-1:0]  ony_q;
	logic [COORD_ZW-1:0]  onz_q;
	logic [RES_W-1:0]     ores_q;
	logic                 olast_q;

	// effective sizes
	logic [10:0]   sx_w, sy_w;
	logic [XW-1:0] sx;
	logic [YW-1:0] sy;
	logic [15:0]   sz;
	logic [PW-1:0] plane;

	always_comb begin
		sx_w = (size_x_q < 8'd3) ? 11'd3 :
			({3'b0, size_x_q} > 11'(MAX_X)) ? 11'(MAX_X) : {3'b0, size_x_q};
		sy_w = (size_y_q < 8'd3) ? 11'd3 :
			({3'b0, size_y_q} > 11'(MAX_Y)) ? 11'(MAX_Y) : {3'b0, size_y_q};
		sx    = XW'(sx_w);
		sy    = YW'(sy_w);
		sz    = (size_z_q < 16'd3) ? 16'd3 : size_z_q;
		plane = PW'(sx) * PW'(sy);
	end

	// node classification at the input
	logic accept, interior, last_node, x_wrap, y_wrap, z_wrap;
	logic signed [VB-1:0] in_val;

	assign accept   = s_tvalid && s_tready;
	assign in_val   = s_tdata[VB-1:0];
	assign interior = (pos_z_q >= 16'd2) && (pos_x_q >= XW'(1)) &&
		((XW+1)'(pos_x_q) + (XW+1)'(1) < (XW+1)'(sx)) &&
		(pos_y_q >= YW'(1)) && ((YW+1)'(pos_y_q) + (YW+1)'(1) < (YW+1)'(sy));
	assign last_node = ((17'(pos_z_q) + 17'd1) == 17'(sz)) &&
		((XW+1)'(pos_x_q) + (XW+1)'(2) == (XW+1)'(sx)) &&
		((YW+1)'(pos_y_q) + (YW+1)'(2) == (YW+1)'(sy));
	assign x_wrap = ((XW+1)'(pos_x_q) + (XW+1)'(1)) >= (XW+1)'(sx);
	assign y_wrap = ((YW+1)'(pos_y_q) + (YW+1)'(1)) >= (YW+1)'(sy);
	assign z_wrap = (17'(pos_z_q) + 17'd1) >= 17'(sz);
	assign cfg_hit = cfg_we && (cfg_index == CFG_SIZE_X || cfg_index == CFG_SIZE_Y ||
		cfg_index == CFG_SIZE_Z);

	// window read address: iptr minus neighbor offset, modulo depth
	logic [AW-1:0] koff, raddr;
	logic [AW:0]   rdiff;
	logic          ram_re;
	logic [VB-1:0] rdata;

	always_comb begin
		case (rd_cnt_q)
			3'd0:    koff = AW'(2 * 32'(plane));
			3'd1:    koff = AW'(plane) - AW'(1);
			3'd2:    koff = AW'(plane) + AW'(1);
			3'd3:    koff = AW'(plane) - AW'(sx);
			3'd4:    koff = AW'(plane) + AW'(sx);
			default: koff = AW'(plane);
		endcase
		rdiff = {1'b0, iptr_q} - {1'b0, koff};
		raddr = rdiff[AW] ? AW'(rdiff + (AW+1)'(DEPTH)) : rdiff[AW-1:0];
	end

	j7s3_ram #(
		.WIDTH(VB),
		.DEPTH(DEPTH)
	) u_window (
		.clk  (clk),
		.we   (accept),
		.waddr(wptr_q),
		.wdata(in_val),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// divide by six: low then high partial product of (dividend / 2) * RECIP3
	logic [MLW-1:0]    m_lo;
	logic [MHW-1:0]    m_hi;
	logic [MLW+RW-1:0] plo_nx;
	logic [MHW+RW-1:0] phi;
	logic [PRW-1:0]    prod;

	assign m_lo   = dvd_q[MLW:1];
	assign m_hi   = dvd_q[SW-1:MLW+1];
	assign plo_nx = (MLW+RW)'(m_lo) * (MLW+RW)'(RECIP3);
	assign phi    = (MHW+RW)'(m_hi) * (MHW+RW)'(RECIP3);
	assign prod   = (PRW'(phi) << MLW) + PRW'(plo_q);

	// quotient back to signed: floor((S+3)/6) = quo - 2^(VB-1)
	logic signed [VB-1:0] qval;
	logic signed [VB:0]   dval;
	logic [SW-1:0]        dvd_init;

	assign qval     = quo_q ^ (VB'(1) << (VB - 1));
	assign dval     = (VB+1)'(qval) - (VB+1)'(center_q);
	assign dvd_init = SW'(sum_q) + SW'(3) + (SW'(3) << VB);

	// residual term and saturating sum
	logic [TW-1:0]    term;
	logic [RES_W:0]   res_add;
	logic [RES_W-1:0] res_new;
	logic             out_free;

	assign term     = TW'(({1'b0, sq_q} + ((2*VB+1)'(1) << (FB - 1))) >> FB);
	assign res_add  = {1'b0, res_q} + (RES_W+1)'(term);
	assign res_new  = res_add[RES_W] ? {RES_W{1'b1}} : res_add[RES_W-1:0];
	assign out_free = !ovalid_q || m_tready;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (accept && interior) state_nx = ST_READ;
			ST_READ: if (rd_cnt_q == 3'(N_READS)) state_nx = ST_DIV;
			ST_DIV:  if (div_cnt_q == DCW'(DIV_STEPS - 1)) state_nx = ST_DIFF;
			ST_DIFF: state_nx = ST_MUL;
			ST_MUL:  state_nx = ST_ACC;
			ST_ACC:  if (out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready = 1'b0;
		ram_re   = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_READ: ram_re = (rd_cnt_q < 3'(N_READS));
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			size_x_q  <= SIZE_RST[7:0];
			size_y_q  <= SIZE_RST[7:0];
			size_z_q  <= SIZE_RST;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			pos_z_q   <= '0;
			res_q     <= '0;
			wptr_q    <= '0;
			rd_cnt_q  <= '0;
			div_cnt_q <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			// register writes restart the grid
			if (cfg_hit) begin
				case (cfg_index)
					CFG_SIZE_X: size_x_q <= cfg_data[7:0];
					CFG_SIZE_Y: size_y_q <= cfg_data[7:0];
					default:    size_z_q <= cfg_data;
				endcase
				pos_x_q <= '0;
				pos_y_q <= '0;
				pos_z_q <= '0;
				res_q   <= '0;
			end else if (accept) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
				pos_x_q <= x_wrap ? '0 : pos_x_q + XW'(1);
				if (x_wrap) begin
					pos_y_q <= y_wrap ? '0 : pos_y_q + YW'(1);
					if (y_wrap) begin
						pos_z_q <= z_wrap ? '0 : pos_z_q + 16'd1;
						if (z_wrap) begin
							res_q <= '0;
						end
					end
				end
			end else if (state_q == ST_ACC && out_free) begin
				res_q <= res_new;
			end
			// read and divide counters
			if (state_q == ST_READ) begin
				rd_cnt_q <= rd_cnt_q + 3'd1;
			end else begin
				rd_cnt_q <= '0;
			end
			if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + DCW'(1);
			end else begin
				div_cnt_q <= '0;
			end
			// output word valid
			if (state_q == ST_ACC && out_free) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			iptr_q <= wptr_q;
			sum_q  <= SW'(in_val);
			ox_q   <= COORD_XW'(pos_x_q);
			oy_q   <= COORD_YW'(pos_y_q);
			oz_q   <= pos_z_q - 16'd1;
			last_q <= last_node;
		end
		if (state_q == ST_READ) begin
			if (rd_cnt_q == 3'(N_READS)) begin
				center_q <= rdata;
				dvd_q    <= dvd_init;
			end else if (rd_cnt_q != 3'd0) begin
				sum_q <= sum_q + SW'($signed(rdata));
			end
		end
		if (state_q == ST_DIV) begin
			if (div_cnt_q == DCW'(0)) begin
				plo_q <= plo_nx;
			end else begin
				quo_q <= prod[RK +: VB];
			end
		end
		if (state_q == ST_DIFF) begin
			ad_q <= dval[VB] ? VB'(-dval) : dval[VB-1:0];
		end
		if (state_q == ST_MUL) begin
			sq_q <= (2*VB)'(ad_q) * (2*VB)'(ad_q);
		end
		if (state_q == ST_ACC && out_free) begin
			onew_q  <= qval;
			onx_q   <= ox_q;
			ony_q   <= oy_q;
			onz_q   <= oz_q;
			ores_q  <= last_q ? res_new : '0;
			olast_q <= last_q;
		end
	end

	// output word
	assign m_tvalid = ovalid_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {2'b00, ores_q, onz_q, ony_q, onx_q, NODE_W'(onew_q)};

	// checks
	`J7S3_ASSERT_NXT(a_interior_reads, clk, arst_n, accept && interior && !cfg_hit,
		state_q == ST_READ && rd_cnt_q == 3'd0)
	`J7S3_ASSERT_IMP(a_read_count, clk, arst_n, state_q == ST_READ,
		rd_cnt_q <= 3'(N_READS))
	`J7S3_ASSERT_IMP(a_div_count, clk, arst_n, state_q == ST_DIV,
		div_cnt_q < DCW'(DIV_STEPS))

endmodule
